// File: sv/svp_pkg.sv
// semver string parser package: payload structs, parser state types, character codes
// and the helper functions used by the parser engine
// no dependencies
`default_nettype none

package svp_pkg;

	localparam int COMPONENT_BITS_DEF = 32;
	localparam int OUT_BITS           = 32;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_V  = 8'h56;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_V = 8'h76;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_EMPTY     = 4'd1;
	localparam logic [3:0] ERR_NO_MINOR  = 4'd2;
	localparam logic [3:0] ERR_NO_PATCH  = 4'd3;
	localparam logic [3:0] ERR_NONNUM    = 4'd4;
	localparam logic [3:0] ERR_LZERO     = 4'd5;
	localparam logic [3:0] ERR_OVERFLOW  = 4'd6;
	localparam logic [3:0] ERR_BAD_PRE   = 4'd7;
	localparam logic [3:0] ERR_BAD_BUILD = 4'd8;
	localparam logic [3:0] ERR_TRAILING  = 4'd9;

	// part errors keep the low bits of the matching error codes
	localparam logic [2:0] PERR_NONE     = 3'd0;
	localparam logic [2:0] PERR_NONNUM   = 3'd4;
	localparam logic [2:0] PERR_LZERO    = 3'd5;
	localparam logic [2:0] PERR_OVERFLOW = 3'd6;

	localparam logic [1:0] PART_LIMIT = 2'd3;
	localparam logic [1:0] PEND_MAX   = 2'd2;

	typedef enum logic [2:0] {
		SEC_CORE  = 3'b001,
		SEC_PRE   = 3'b010,
		SEC_BUILD = 3'b100
	} sec_t;

	typedef struct packed {
		logic over;
		logic long_part;
		logic first_zero;
		logic nondigit;
		logic nonempty;
	} pflags_t;

	typedef struct packed {
		logic       closed;
		logic       fail;
		logic [1:0] part;
		logic [1:0] pend;
	} len_t;

	typedef struct packed {
		sec_t       section;
		logic       at_start;
		logic       body_seen;
		logic       pre_seen;
		logic [1:0] part_cnt;
		pflags_t    pf;
		logic [2:0] part_err;
		logic       ident_ne;
		logic [1:0] sec_inv;
		len_t       len;
	} ctl_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_char;
		logic       last;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  error_code;
		logic [31:0] major_value;
		logic [31:0] minor_value;
		logic [31:0] patch_value;
		logic        has_prerelease;
		logic        has_build;
		logic        from_fallback;
	} out_t;

	function automatic ctl_t ctl_reset();
		ctl_t r;
		r          = '0;
		r.section  = SEC_CORE;
		r.at_start = 1'b1;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
			((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_MINUS);
	endfunction

	// close a core part: record its error if it is one of the first three
	function automatic ctl_t finish_part(ctl_t s);
		ctl_t       r;
		logic [2:0] e;
		r = s;
		e = PERR_NONE;
		if (s.part_cnt < PART_LIMIT) begin
			if (!s.pf.nonempty || s.pf.nondigit) begin
				e = PERR_NONNUM;
			end else if (s.pf.first_zero && s.pf.long_part) begin
				e = PERR_LZERO;
			end else if (s.pf.over) begin
				e = PERR_OVERFLOW;
			end
			if ((s.part_err == PERR_NONE) && (e != PERR_NONE)) begin
				r.part_err = e;
			end
		end
		r.pf = '0;
		return r;
	endfunction

	// close a prerelease or build identifier, flag the section if it was empty
	function automatic ctl_t close_ident(ctl_t s);
		ctl_t r;
		r = s;
		if (!s.ident_ne) begin
			if (s.section == SEC_PRE) begin
				r.sec_inv[0] = 1'b1;
			end else begin
				r.sec_inv[1] = 1'b1;
			end
		end
		r.ident_ne = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/svp_in_reg.sv
// semver string parser input register: holds one accepted request for the engine
// depends on svp_pkg
`default_nettype none

module svp_in_reg
	import svp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	input  wire logic take,
	output logic      valid_s1,
	output in_t       item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/svp_engine.sv
// semver string parser engine: parser state, per-character update and end-of-string result
// depends on svp_pkg
`default_nettype none

module svp_engine
	import svp_pkg::*;
#(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire in_t  item,
	input  wire logic lenient,
	output logic      res_valid,
	output out_t      res
);

	localparam int CB = COMPONENT_BITS;
	localparam int W  = COMPONENT_BITS + 4;

	ctl_t            ctl_q, ctl_nx;
	logic [CB-1:0]   strict_q [3];
	logic [CB-1:0]   strict_nx [3];
	logic [CB-1:0]   len_comp_q [3];
	logic [CB-1:0]   len_comp_nx [3];

	logic [7:0]      c;
	logic [3:0]      dig;
	logic [CB-1:0]   s_acc, l_acc;
	logic [W-1:0]    s_sum, l_sum;
	logic            s_ovf, l_ovf;
	logic [1:0]      lp_tgt;

	assign c   = item.char_byte;
	assign dig = c[3:0];

	// operand selection for the two decimal accumulators
	always_comb begin
		if (ctl_q.len.pend == PEND_MAX) begin
			lp_tgt = PART_LIMIT;
		end else if ((ctl_q.len.pend == 2'd1) && (ctl_q.len.part != PART_LIMIT)) begin
			lp_tgt = ctl_q.len.part + 2'd1;
		end else begin
			lp_tgt = ctl_q.len.part;
		end
		unique case (ctl_q.part_cnt)
			2'd0:    s_acc = strict_q[0];
			2'd1:    s_acc = strict_q[1];
			2'd2:    s_acc = strict_q[2];
			default: s_acc = '0;
		endcase
		unique case (lp_tgt)
			2'd0:    l_acc = len_comp_q[0];
			2'd1:    l_acc = len_comp_q[1];
			2'd2:    l_acc = len_comp_q[2];
			default: l_acc = '0;
		endcase
	end

	// acc * 10 + digit, overflow when anything lands above the component width
	assign s_sum = (W'(s_acc) << 3) + (W'(s_acc) << 1) + W'(dig);
	assign l_sum = (W'(l_acc) << 3) + (W'(l_acc) << 1) + W'(dig);
	assign s_ovf = |s_sum[W-1:CB];
	assign l_ovf = |l_sum[W-1:CB];

	always_comb begin
		ctl_t       nx, fin;
		logic       first;
		logic [3:0] err;
		nx          = ctl_q;
		fin         = ctl_q;
		first       = 1'b0;
		err         = ERR_NONE;
		strict_nx   = strict_q;
		len_comp_nx = len_comp_q;
		res         = '0;

		if (item.has_char) begin
			if (nx.at_start && ((c == CH_LOW_V) || (c == CH_UP_V))) begin
				nx.at_start = 1'b0;
			end else begin
				first        = !nx.body_seen;
				nx.at_start  = 1'b0;
				nx.body_seen = 1'b1;

				unique case (nx.section)
					SEC_CORE: begin
						priority if (c == CH_DOT) begin
							nx = finish_part(nx);
							if (nx.part_cnt < PART_LIMIT) begin
								nx.part_cnt = nx.part_cnt + 2'd1;
							end
						end else if (c == CH_MINUS) begin
							nx          = finish_part(nx);
							nx.section  = SEC_PRE;
							nx.pre_seen = 1'b1;
							nx.ident_ne = 1'b0;
						end else if (c == CH_PLUS) begin
							nx          = finish_part(nx);
							nx.section  = SEC_BUILD;
							nx.ident_ne = 1'b0;
						end else begin
							if (!nx.pf.nonempty) begin
								if (c == CH_ZERO) begin
									nx.pf.first_zero = 1'b1;
								end
							end else begin
								nx.pf.long_part = 1'b1;
							end
							nx.pf.nonempty = 1'b1;
							if (!is_digit(c)) begin
								nx.pf.nondigit = 1'b1;
							end else if ((nx.part_cnt < PART_LIMIT) && !nx.pf.over) begin
								if (s_ovf) begin
									nx.pf.over = 1'b1;
								end else begin
									for (int i = 0; i < 3; i++) begin
										if (nx.part_cnt == 2'(i)) begin
											strict_nx[i] = s_sum[CB-1:0];
										end
									end
								end
							end
						end
					end
					SEC_PRE, SEC_BUILD: begin
						priority if ((nx.section == SEC_PRE) && (c == CH_PLUS)) begin
							nx         = close_ident(nx);
							nx.section = SEC_BUILD;
						end else if (c == CH_DOT) begin
							nx = close_ident(nx);
						end else if (is_ident(c)) begin
							nx.ident_ne = 1'b1;
						end else if (nx.section == SEC_PRE) begin
							nx.sec_inv[0] = 1'b1;
						end else begin
							nx.sec_inv[1] = 1'b1;
						end
					end
					default: begin
					end
				endcase

				// prefix digit/dot run for the lenient fallback
				if (!nx.len.closed && !nx.len.fail) begin
					if (first && !is_digit(c)) begin
						nx.len.fail = 1'b1;
					end else if (is_digit(c)) begin
						if ((nx.len.pend == PEND_MAX) && (nx.len.part < 2'd2)) begin
							nx.len.fail = 1'b1;
						end else if ((lp_tgt != PART_LIMIT) && l_ovf) begin
							nx.len.fail = 1'b1;
						end else begin
							nx.len.part = lp_tgt;
							nx.len.pend = '0;
							for (int i = 0; i < 3; i++) begin
								if (lp_tgt == 2'(i)) begin
									len_comp_nx[i] = l_sum[CB-1:0];
								end
							end
						end
					end else if (c == CH_DOT) begin
						if (nx.len.pend < PEND_MAX) begin
							nx.len.pend = nx.len.pend + 2'd1;
						end
					end else begin
						nx.len.closed = 1'b1;
					end
				end
			end
		end

		if (item.last) begin
			fin = nx;
			if (!fin.body_seen) begin
				err = ERR_EMPTY;
			end else begin
				if (fin.section == SEC_CORE) begin
					fin = finish_part(fin);
				end else begin
					fin = close_ident(fin);
				end
				priority if (fin.sec_inv[1]) begin
					err = ERR_BAD_BUILD;
				end else if (fin.sec_inv[0]) begin
					err = ERR_BAD_PRE;
				end else if (fin.part_cnt == 2'd0) begin
					err = ERR_NO_MINOR;
				end else if (fin.part_cnt == 2'd1) begin
					err = ERR_NO_PATCH;
				end else if (fin.part_cnt == PART_LIMIT) begin
					err = ERR_TRAILING;
				end else begin
					err = {1'b0, fin.part_err};
				end
			end
			res.error_code = err;
			if (err == ERR_NONE) begin
				res.ok             = 1'b1;
				res.major_value    = OUT_BITS'(strict_nx[0]);
				res.minor_value    = OUT_BITS'(strict_nx[1]);
				res.patch_value    = OUT_BITS'(strict_nx[2]);
				res.has_prerelease = fin.pre_seen;
				res.has_build      = (fin.section == SEC_BUILD);
			end else if (lenient && fin.body_seen && !fin.len.fail) begin
				res.ok            = 1'b1;
				res.major_value   = OUT_BITS'(len_comp_nx[0]);
				res.minor_value   = OUT_BITS'(len_comp_nx[1]);
				res.patch_value   = OUT_BITS'(len_comp_nx[2]);
				res.from_fallback = 1'b1;
			end
			nx = ctl_reset();
			for (int i = 0; i < 3; i++) begin
				strict_nx[i]   = '0;
				len_comp_nx[i] = '0;
			end
		end
		ctl_nx = nx;
	end

	assign res_valid = step && item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= ctl_reset();
			for (int i = 0; i < 3; i++) begin
				strict_q[i]   <= '0;
				len_comp_q[i] <= '0;
			end
		end else if (step) begin
			ctl_q      <= ctl_nx;
			strict_q   <= strict_nx;
			len_comp_q <= len_comp_nx;
		end
	end

`ifndef SYNTHESIS
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (ctl_q.at_start && !ctl_q.body_seen))
		else $error("parser state not cleared after result");

	a_flags_only_in_core: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.section != SEC_CORE) |-> (ctl_q.pf == '0))
		else $error("part flags left set outside the core");

	a_strict_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.ok && !res.from_fallback) |-> (res.error_code == ERR_NONE))
		else $error("strict result with an error code");

	a_fresh_string: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl_q.body_seen |-> ((ctl_q.section == SEC_CORE) && (ctl_q.part_cnt == 2'd0) &&
			!ctl_q.len.fail))
		else $error("string state advanced without a body character");
`endif

endmodule

`default_nettype wire

// File: sv/semver_string_parser.sv
// a request with last passes the input register and the engine, then the result register
// throughput: one character request per cycle; a request with last waits while the
// previous result has not been taken
// the rate is set by the combinational state update between input and result registers
// reset: arst_n clears all parser state, empties both registers, sets lenient_q to 1
// top level of the semver string parser; depends on svp_pkg, svp_in_reg, svp_engine
`default_nettype none

module semver_string_parser
	import svp_pkg::*;
#(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic cfg_data
);

	logic lenient_q;
	logic valid_s1;
	in_t  item_s1;
	logic take;
	logic res_valid;
	out_t res;
	logic out_valid_q;
	out_t out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lenient_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			lenient_q <= cfg_data;
		end
	end

	// a request with last waits while an earlier result is still pending
	assign take = valid_s1 && (!item_s1.last || !out_valid_q || out_ready);

	svp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	svp_engine #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.item      (item_s1),
		.lenient   (lenient_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid_q)
		else $error("result not presented after the end of a string");

	a_held_item_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> (valid_s1 && $stable(item_s1)))
		else $error("held input request lost or changed");
`endif

endmodule

`default_nettype wire
